// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define BPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define BPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bpc_pkg.sv =====
`default_nettype none
package bpc_pkg;

  localparam int TICK_COUNT_WIDTH = 16;
  localparam int REG_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CMP_W = (TICK_COUNT_WIDTH > REG_W) ? TICK_COUNT_WIDTH : REG_W;

  localparam logic [REG_W-1:0] DEF_DEBOUNCE = REG_W'(50);
  localparam logic [REG_W-1:0] DEF_LONG     = REG_W'(3000);
  localparam logic [REG_W-1:0] DEF_GAP      = REG_W'(200);

  localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

  typedef logic [TICK_COUNT_WIDTH-1:0] tick_t;
  typedef logic [REG_W-1:0]            reg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_GAP      = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_DEB1        = 3'd1,
    ST_WAIT_REL1   = 3'd2,
    ST_WAIT_PRESS2 = 3'd3,
    ST_DEB2        = 3'd4,
    ST_WAIT_REL2   = 3'd5
  } state_t;

  typedef enum logic [1:0] {
    PT_NONE   = 2'd0,
    PT_SINGLE = 2'd1,
    PT_DOUBLE = 2'd2,
    PT_LONG   = 2'd3
  } press_t;

  typedef struct packed {
    reg_t debounce_ticks;
    reg_t long_press_ticks;
    reg_t double_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] press_type;
    logic [2:0] machine_state;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/bpc_ifs.sv =====
`default_nettype none
interface bpc_in_if;
  logic valid;
  logic ready;
  logic button_level;
  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_type;
  logic [2:0] machine_state;
  modport source (output valid, output press_type, output machine_state, input ready);
  modport sink   (input valid, input press_type, input machine_state, output ready);
endinterface

interface bpc_cfg_if;
  import bpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/bpc_cfg.sv =====
`default_nettype none
module bpc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire bpc_pkg::reg_t                   wr_data,
  output bpc_pkg::cfg_t                        cfg
);
  import bpc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_DEBOUNCE: cfg_nxt.debounce_ticks   = wr_data;
        REG_LONG:     cfg_nxt.long_press_ticks = wr_data;
        REG_GAP:      cfg_nxt.double_gap_ticks = wr_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEF_DEBOUNCE;
      cfg_r.long_press_ticks <= DEF_LONG;
      cfg_r.double_gap_ticks <= DEF_GAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== sv/bpc_fsm.sv =====
`default_nettype none
`include "assert_macros.svh"
module bpc_fsm (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic          button_level,
  input  wire bpc_pkg::cfg_t cfg,
  output bpc_pkg::res_t      res_nxt
);
  import bpc_pkg::*;

  state_t state_r, state_nxt;
  tick_t  elapsed_r, elapsed_nxt;
  press_t type_r, type_nxt;

  logic  pressed;
  tick_t inc;
  logic  deb_done, long_done, gap_done;

  assign pressed = !button_level;
  assign inc     = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + 1'b1;

  assign deb_done  = CMP_W'(inc) > CMP_W'(cfg.debounce_ticks);
  assign long_done = CMP_W'(inc) > CMP_W'(cfg.long_press_ticks);
  assign gap_done  = CMP_W'(inc) > CMP_W'(cfg.double_gap_ticks);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:        if (pressed) state_nxt = ST_DEB1;
      ST_DEB1:        if (deb_done) state_nxt = pressed ? ST_WAIT_REL1 : ST_IDLE;
      ST_WAIT_REL1:   if (!pressed) state_nxt = long_done ? ST_IDLE : ST_WAIT_PRESS2;
      ST_WAIT_PRESS2: begin
        // expired gap wins over a press on the same tick
        if (gap_done) state_nxt = ST_IDLE;
        else if (pressed) state_nxt = ST_DEB2;
      end
      ST_DEB2:        if (deb_done) state_nxt = pressed ? ST_WAIT_REL2 : ST_IDLE;
      ST_WAIT_REL2:   if (!pressed) state_nxt = ST_IDLE;
      default:        state_nxt = state_r;
    endcase
  end

  // Counter and press type
  always_comb begin
    elapsed_nxt = inc;
    type_nxt    = type_r;
    case (state_r)
      ST_IDLE: begin
        type_nxt = PT_NONE;
        if (pressed) elapsed_nxt = '0;
      end
      ST_DEB1, ST_DEB2: begin
        if (deb_done) elapsed_nxt = '0;
      end
      ST_WAIT_REL1: begin
        if (!pressed) begin
          if (long_done) type_nxt = PT_LONG;
          else elapsed_nxt = '0;
        end
      end
      ST_WAIT_PRESS2: begin
        if (gap_done) type_nxt = PT_SINGLE;
        else if (pressed) elapsed_nxt = '0;
      end
      ST_WAIT_REL2: begin
        if (!pressed) type_nxt = PT_DOUBLE;
      end
      default: begin
        type_nxt = type_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      elapsed_r <= '0;
      type_r    <= PT_NONE;
    end else if (acc) begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
      type_r    <= type_nxt;
    end
  end

  assign res_nxt.press_type    = type_nxt;
  assign res_nxt.machine_state = state_nxt;

  `BPC_ASSERT(a_hold_idle, !acc |=> $stable(state_r) && $stable(elapsed_r) && $stable(type_r),
    "classifier state moved without a request")
  `BPC_ASSERT(a_mark_on_press, (acc && state_r == ST_IDLE && !button_level) |=> elapsed_r == '0,
    "press from idle did not mark the counter")
  `BPC_ASSERT(a_double, (acc && state_r == ST_WAIT_REL2 && button_level) |=>
    (type_r == PT_DOUBLE && state_r == ST_IDLE), "second release did not give a double press")

endmodule
`default_nettype wire

// ===== sv/bpc_outbuf.sv =====
`default_nettype none
`include "assert_macros.svh"
module bpc_outbuf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bpc_pkg::res_t push_data,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bpc_pkg::res_t      out_data
);
  import bpc_pkg::*;

  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      // drain skid first; no push can arrive while it is full
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BPC_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_r |-> out_valid_r,
    "skid holds a request while the output stage is empty")
  `BPC_ASSERT(a_skid_drains, (skid_valid_r && out_ready) |=> (!skid_valid_r && out_valid_r),
    "skid entry not moved forward on drain")

endmodule
`default_nettype wire

// ===== sv/button_press_classifier.sv =====
// Results are registered in the output stage, or the skid stage while out_ch stalls.
// Throughput: one request per cycle; the state update and threshold compares are one
//   register-to-register pass, and a one-entry skid stage keeps in_ch.ready up while
//   a result waits, dropping it only when the skid entry is occupied.
// Reset (rst_n low, synchronous): idle state, counter zero, press type none, thresholds
//   back to 50 / 3000 / 200, output and skid stages empty.
`default_nettype none
module button_press_classifier (
  input  wire logic clk,
  input  wire logic rst_n,
  bpc_in_if.sink    in_ch,
  bpc_out_if.source out_ch,
  bpc_cfg_if.sink   cfg_ch
);
  import bpc_pkg::*;

  cfg_t cfg;
  res_t res_nxt;
  res_t out_data;
  logic in_acc;
  logic in_ready;
  logic cfg_acc;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;
  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid && in_ready;

  bpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_acc),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  bpc_fsm u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .button_level (in_ch.button_level),
    .cfg          (cfg),
    .res_nxt      (res_nxt)
  );

  bpc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res_nxt),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.press_type    = out_data.press_type;
  assign out_ch.machine_state = out_data.machine_state;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, must be ignored
  localparam int MAX_PRINTED = 40;

  logic clk;
  logic rst_n;

  bpc_in_if  in_ch();
  bpc_out_if out_ch();
  bpc_cfg_if cfg_ch();

  button_press_classifier dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Mirror of the classifier: thresholds, state, counter and sticky press type
  reg_t   debounce_lim = DEF_DEBOUNCE;
  reg_t   long_lim     = DEF_LONG;
  reg_t   gap_lim      = DEF_GAP;
  state_t phase_now    = ST_IDLE;
  tick_t  ticks_since  = '0;
  press_t sticky_press = PT_NONE;

  res_t expected_presses[$];
  res_t oldest;
  int   mismatches   = 0;
  bit   send_gaps_on = 1'b0;
  bit   recv_stall_on = 1'b0;
  int   hold_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Advance the mirror by one sampled level and queue the result it produces.
  task automatic classify_level(input logic lvl);
    logic pressed;
    res_t r;
    pressed = (lvl == 1'b0);
    if (ticks_since != TICK_MAX) ticks_since++;
    case (phase_now)
      ST_IDLE: begin
        sticky_press = PT_NONE;
        if (pressed) begin
          phase_now = ST_DEB1;
          ticks_since = '0;
        end
      end
      ST_DEB1: begin
        if (ticks_since > debounce_lim) begin
          ticks_since = '0;
          phase_now = pressed ? ST_WAIT_REL1 : ST_IDLE;
        end
      end
      ST_WAIT_REL1: begin
        if (!pressed) begin
          if (ticks_since > long_lim) begin
            sticky_press = PT_LONG;
            phase_now = ST_IDLE;
          end else begin
            ticks_since = '0;
            phase_now = ST_WAIT_PRESS2;
          end
        end
      end
      ST_WAIT_PRESS2: begin
        // gap expiry wins over a press on the same tick
        if (ticks_since > gap_lim) begin
          sticky_press = PT_SINGLE;
          phase_now = ST_IDLE;
        end else if (pressed) begin
          phase_now = ST_DEB2;
          ticks_since = '0;
        end
      end
      ST_DEB2: begin
        if (ticks_since > debounce_lim) begin
          ticks_since = '0;
          phase_now = pressed ? ST_WAIT_REL2 : ST_IDLE;
        end
      end
      ST_WAIT_REL2: begin
        if (!pressed) begin
          sticky_press = PT_DOUBLE;
          phase_now = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
    r.press_type    = sticky_press;
    r.machine_state = phase_now;
    expected_presses.push_back(r);
  endtask

  // Send count requests of the same level; valid stays up between them unless send_gaps_on.
  task automatic send_run(input logic lvl, input int count);
    int gap;
    repeat (count) begin
      gap = send_gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid        <= 1'b1;
      in_ch.button_level <= lvl;
      do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
      classify_level(lvl);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_presses.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input reg_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    if (idx == REG_DEBOUNCE) debounce_lim = val;
    else if (idx == REG_LONG) long_lim = val;
    else if (idx == REG_GAP) gap_lim = val;
    @(posedge clk);
  endtask

  // Receiver: optional random stall before each result, plus a long hold-off on request.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = recv_stall_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_presses.size() == 0) begin
        flag_mismatch("result with no request pending");
      end else begin
        oldest = expected_presses.pop_front();
        if (out_ch.press_type !== oldest.press_type)
          flag_mismatch($sformatf("press_type got %0d want %0d",
                                  out_ch.press_type, oldest.press_type));
        if (out_ch.machine_state !== oldest.machine_state)
          flag_mismatch($sformatf("machine_state got %0d want %0d",
                                  out_ch.machine_state, oldest.machine_state));
      end
    end
  end

  // Reset thresholds: single press at debounce 50 and gap 200.
  task automatic test_reset_defaults();
    send_gaps_on  = 1'b0;
    recv_stall_on = 1'b0;
    send_run(1'b1, 2);
    send_run(1'b0, 52);
    send_run(1'b1, 1);
    send_run(1'b1, 202);
    wait_drained();
  endtask

  task automatic test_directed_cases();
    wait_drained();
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_LONG, 16'd1);
    write_reg(REG_GAP, 16'd1);
    write_reg(REG_SPARE, 16'hFFFF);
    send_gaps_on  = 1'b1;
    recv_stall_on = 1'b1;
    // failed debounce drops back silently
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    // long press, then the idle step clears it
    send_run(1'b0, 4);
    send_run(1'b1, 2);
    // single press by gap expiry
    send_run(1'b0, 2);
    send_run(1'b1, 3);
    // double press
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    // press on the tick the gap expires still gives a single press
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    wait_drained();
    write_reg(REG_DEBOUNCE, 16'd1);
    write_reg(REG_LONG, 16'd4);
    write_reg(REG_GAP, 16'd3);
    send_gaps_on  = 1'b0;
    recv_stall_on = 1'b0;
    hold_cycles   = 60;
    repeat (3) begin
      send_run(1'b0, 4);
      send_run(1'b1, 6);
    end
    wait_drained();
  endtask

  task automatic run_random_phase(input reg_t deb, input reg_t lng, input reg_t gap,
                                  input int n_items);
    int   sent;
    int   span;
    int   len;
    logic lvl;
    wait_drained();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG, lng);
    write_reg(REG_GAP, gap);
    write_reg(REG_SPARE, reg_t'($urandom));
    span = int'(deb);
    if (int'(lng) > span) span = int'(lng);
    if (int'(gap) > span) span = int'(gap);
    span = span + 3;
    if (span > 40) span = 40;
    sent = 0;
    lvl  = 1'b0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, span);
        send_run(lvl, len);
        sent += len;
        lvl = ~lvl;
      end else begin
        send_run(logic'($urandom_range(0, 1)), 1);
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    send_gaps_on  = 1'b1;
    recv_stall_on = 1'b1;
    run_random_phase(reg_t'($urandom_range(0, 2)), reg_t'($urandom_range(2, 10)),
                     reg_t'($urandom_range(1, 6)), 40);
    send_gaps_on  = 1'b0;
    recv_stall_on = 1'b0;
    run_random_phase(16'd0, 16'd0, 16'd0, 30);
    send_gaps_on  = 1'b1;
    recv_stall_on = 1'b0;
    run_random_phase(reg_t'($urandom_range(0, 3)), 16'hFFFF,
                     reg_t'($urandom_range(0, 8)), 40);
    send_gaps_on  = 1'b0;
    recv_stall_on = 1'b1;
    run_random_phase(reg_t'($urandom_range(0, 3)), reg_t'($urandom_range(0, 12)),
                     reg_t'($urandom_range(0, 8)), 40);
    wait_drained();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.button_level = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_DEBOUNCE;
    cfg_ch.data        = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/bpc_pkg.sv
sv/bpc_ifs.sv
sv/bpc_cfg.sv
sv/bpc_fsm.sv
sv/bpc_outbuf.sv
sv/button_press_classifier.sv
verif/testbench.sv
